/* sv/marked_id_set_table_unit_defines.svh */
// ----------------------------------------------------------------------------
// Marked id set table - assertion macros
// Concurrent assertion helpers; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef MARKED_ID_SET_TABLE_UNIT_DEFINES_SVH
`define MARKED_ID_SET_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// plain property check, reset masked
`define MIDS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// implication check built on the one above
`define MIDS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  `MIDS_ASSERT(lbl, clk, rst_n, (ante) |-> cons, msg)
`else
`define MIDS_ASSERT(lbl, clk, rst_n, prop, msg)
`define MIDS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* sv/mids_pkg.sv */
// ----------------------------------------------------------------------------
// Marked id set table - package
// Operation, status and mark codes plus sequencer states.
// ----------------------------------------------------------------------------
package mids_pkg;

  localparam int unsigned IdW    = 32;
  localparam int unsigned FuncW  = 3;
  localparam int unsigned StatW  = 2;
  localparam int unsigned MarkW  = 2;
  localparam int unsigned CountW = 7;

  typedef enum logic [FuncW-1:0] {
    FUNC_ADD        = 3'd0,
    FUNC_CLEAR      = 3'd1,
    FUNC_TAKE_NEW   = 3'd2,
    FUNC_TAKE_STALE = 3'd3,
    FUNC_REMOVE     = 3'd4
  } func_e;

  typedef enum logic [StatW-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NONE    = 2'd1,
    STATUS_PRESENT = 2'd2,
    STATUS_FULL    = 2'd3
  } status_e;

  typedef enum logic [MarkW-1:0] {
    MARK_SEEN  = 2'd0,
    MARK_NEW   = 2'd1,
    MARK_STALE = 2'd2
  } mark_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_CLEAR,
    FSM_SHIFT,
    FSM_RESP
  } fsm_e;

endpackage

/* sv/mids_in_if.sv */
// ----------------------------------------------------------------------------
// Marked id set table - command channel
// valid/ready channel carrying one operation beat.
// ----------------------------------------------------------------------------
interface mids_in_if
  import mids_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [FuncW-1:0]  func;
  logic signed [IdW-1:0] id;

  modport source (output valid, output func, output id, input ready);
  modport sink   (input valid, input func, input id, output ready);
endinterface

/* sv/mids_out_if.sv */
// ----------------------------------------------------------------------------
// Marked id set table - result channel
// valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface mids_out_if
  import mids_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [StatW-1:0]      status;
  logic signed [IdW-1:0] id_out;
  logic [CountW-1:0]     count;

  modport source (output valid, output status, output id_out, output count, input ready);
  modport sink   (input valid, input status, input id_out, input count, output ready);
endinterface

/* sv/mids_ram.sv */
// ----------------------------------------------------------------------------
// Marked id set table - generic RAM
// One write port, one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
module mids_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/marked_id_set_table_unit.sv */
// Flow: unused codes go straight to the response, clear marks every entry stale,
//   and add, take and remove scan the table in order (one entry a cycle).
// Commands: one item at a time, bounded by the single read port of the id/mark
//   RAMs; the next beat is taken while a result waits.
// Reset clears control and the count; the table is empty at once, RAM contents
//   are never cleared.
// ----------------------------------------------------------------------------
// Marked id set table unit
// Ordered table of distinct ids with new/seen/stale marks, driven by a small
// sequencer over one pipelined RAM read port and one write port.
// ----------------------------------------------------------------------------
`include "marked_id_set_table_unit_defines.svh"

module marked_id_set_table_unit
  import mids_pkg::*;
#(
  parameter int unsigned MAX_IDS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  mids_in_if.sink    in_i,
  mids_out_if.source out_o
);

  localparam int unsigned AddrW = $clog2(MAX_IDS);
  localparam int unsigned CntW  = $clog2(MAX_IDS + 1);

  // sequencer and command registers
  fsm_e              state_q, state_d;
  func_e             func_q, func_d;
  logic [IdW-1:0]    id_q, id_d;
  logic [CntW-1:0]   cnt_q, cnt_d;    // entries held
  logic [CntW-1:0]   ptr_q, ptr_d;    // next RAM read / clear address
  logic              pend_q, pend_d;  // read data for pidx_q arrives this cycle
  logic [CntW-1:0]   pidx_q, pidx_d;

  // result being built and output register
  status_e           res_stat_q, res_stat_d;
  logic [IdW-1:0]    res_id_q, res_id_d;
  logic              out_vld_q, out_vld_d;
  logic [StatW-1:0]  out_stat_q, out_stat_d;
  logic [IdW-1:0]    out_id_q, out_id_d;
  logic [CountW-1:0] out_cnt_q, out_cnt_d;

  // RAM ports
  logic              ids_we, marks_we;
  logic [CntW-1:0]   waddr;
  logic [IdW-1:0]    ids_wdata, ids_rdata;
  logic [MarkW-1:0]  marks_wdata, marks_rdata;

  logic in_acc, out_acc, issue, hit, scan_hit, scan_end, out_free;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_acc  = out_vld_q && out_o.ready;
  assign out_free = !out_vld_q || out_o.ready;
  assign issue    = ptr_q < cnt_q;

  // match test on the entry whose read data is back this cycle;
  // take stale and remove start at entry 1, so entry 0 is never touched
  always_comb begin
    case (func_q)
      FUNC_ADD, FUNC_REMOVE: hit = ids_rdata == id_q;
      FUNC_TAKE_NEW:         hit = marks_rdata == MARK_NEW;
      FUNC_TAKE_STALE:       hit = marks_rdata == MARK_STALE;
      default:               hit = 1'b0;
    endcase
  end

  assign scan_hit = (state_q == FSM_SCAN) && pend_q && hit;
  assign scan_end = (state_q == FSM_SCAN) && !pend_q && !issue;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (in_acc) begin
          case (func_e'(in_i.func))
            FUNC_ADD, FUNC_TAKE_NEW,
            FUNC_TAKE_STALE, FUNC_REMOVE: state_d = FSM_SCAN;
            FUNC_CLEAR:                   state_d = FSM_CLEAR;
            default:                      state_d = FSM_RESP;
          endcase
        end
      end
      FSM_SCAN: begin
        if (scan_hit) begin
          if (func_q == FUNC_TAKE_STALE || func_q == FUNC_REMOVE) begin
            state_d = FSM_SHIFT;
          end else begin
            state_d = FSM_RESP;
          end
        end else if (scan_end) begin
          state_d = FSM_RESP;
        end
      end
      FSM_CLEAR: begin
        if (!issue) state_d = FSM_RESP;
      end
      FSM_SHIFT: begin
        if (!issue && !pend_q) state_d = FSM_RESP;
      end
      FSM_RESP: begin
        if (out_free) state_d = FSM_IDLE;
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    func_d      = func_q;
    id_d        = id_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    pend_d      = 1'b0;
    pidx_d      = pidx_q;
    res_stat_d  = res_stat_q;
    res_id_d    = res_id_q;
    out_vld_d   = out_vld_q;
    out_stat_d  = out_stat_q;
    out_id_d    = out_id_q;
    out_cnt_d   = out_cnt_q;
    ids_we      = 1'b0;
    marks_we    = 1'b0;
    waddr       = pidx_q;
    ids_wdata   = ids_rdata;
    marks_wdata = marks_rdata;

    if (out_acc) out_vld_d = 1'b0;

    case (state_q)
      FSM_IDLE: begin
        if (in_acc) begin
          func_d   = func_e'(in_i.func);
          id_d     = in_i.id;
          res_id_d = '0;
          case (func_e'(in_i.func))
            FUNC_TAKE_NEW: begin
              res_stat_d = STATUS_NONE;
              ptr_d      = '0;
            end
            FUNC_TAKE_STALE, FUNC_REMOVE: begin
              res_stat_d = STATUS_NONE;
              ptr_d      = CntW'(1);
            end
            default: begin
              res_stat_d = STATUS_OK;
              ptr_d      = '0;
            end
          endcase
        end
      end
      FSM_SCAN: begin
        // one read issued per cycle, compared in the next cycle on the registered read data
        pend_d = issue;
        pidx_d = ptr_q;
        if (issue) ptr_d = ptr_q + CntW'(1);
        if (scan_hit) begin
          pend_d = 1'b0;
          case (func_q)
            FUNC_ADD: begin
              marks_we    = 1'b1;
              marks_wdata = MARK_SEEN;
              res_stat_d  = STATUS_PRESENT;
            end
            FUNC_TAKE_NEW: begin
              marks_we    = 1'b1;
              marks_wdata = MARK_SEEN;
              res_stat_d  = STATUS_OK;
              res_id_d    = ids_rdata;
            end
            FUNC_TAKE_STALE: begin
              res_stat_d = STATUS_OK;
              res_id_d   = ids_rdata;
              ptr_d      = pidx_q + CntW'(1);
            end
            default: begin
              res_stat_d = STATUS_OK;
              ptr_d      = pidx_q + CntW'(1);
            end
          endcase
        end else if (scan_end && func_q == FUNC_ADD) begin
          if (cnt_q >= CntW'(MAX_IDS)) begin
            res_stat_d = STATUS_FULL;
          end else begin
            ids_we      = 1'b1;
            marks_we    = 1'b1;
            waddr       = cnt_q;
            ids_wdata   = id_q;
            marks_wdata = MARK_NEW;
            cnt_d       = cnt_q + CntW'(1);
          end
        end
      end
      FSM_CLEAR: begin
        if (issue) begin
          marks_we    = 1'b1;
          waddr       = ptr_q;
          marks_wdata = MARK_STALE;
          ptr_d       = ptr_q + CntW'(1);
        end
      end
      FSM_SHIFT: begin
        // move entry k+1 down to k, keeping order
        pend_d = issue;
        pidx_d = ptr_q;
        if (issue) ptr_d = ptr_q + CntW'(1);
        if (pend_q) begin
          ids_we   = 1'b1;
          marks_we = 1'b1;
          waddr    = pidx_q - CntW'(1);
        end
        if (!issue && !pend_q) cnt_d = cnt_q - CntW'(1);
      end
      FSM_RESP: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_stat_d = res_stat_q;
          out_id_d   = res_id_q;
          out_cnt_d  = CountW'(cnt_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FSM_IDLE;
      cnt_q     <= '0;
      ptr_q     <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      ptr_q     <= ptr_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    id_q       <= id_d;
    pidx_q     <= pidx_d;
    res_stat_q <= res_stat_d;
    res_id_q   <= res_id_d;
    out_stat_q <= out_stat_d;
    out_id_q   <= out_id_d;
    out_cnt_q  <= out_cnt_d;
  end

  mids_ram #(
    .Width (IdW),
    .Depth (MAX_IDS)
  ) u_ids_ram (
    .clk_i   (clk_i),
    .we_i    (ids_we),
    .waddr_i (waddr[AddrW-1:0]),
    .wdata_i (ids_wdata),
    .raddr_i (ptr_q[AddrW-1:0]),
    .rdata_o (ids_rdata)
  );

  mids_ram #(
    .Width (MarkW),
    .Depth (MAX_IDS)
  ) u_marks_ram (
    .clk_i   (clk_i),
    .we_i    (marks_we),
    .waddr_i (waddr[AddrW-1:0]),
    .wdata_i (marks_wdata),
    .raddr_i (ptr_q[AddrW-1:0]),
    .rdata_o (marks_rdata)
  );

  assign in_i.ready   = state_q == FSM_IDLE;
  assign out_o.valid  = out_vld_q;
  assign out_o.status = out_stat_q;
  assign out_o.id_out = out_id_q;
  assign out_o.count  = out_cnt_q;

  // checks
  `MIDS_ASSERT(a_cnt_max, clk_i, rst_ni, cnt_q <= CntW'(MAX_IDS), "entry count above table size")
  `MIDS_ASSERT_IMPL(a_busy, clk_i, rst_ni, in_acc, ##1 (state_q != FSM_IDLE), "idle after beat")
  `MIDS_ASSERT_IMPL(a_shift, clk_i, rst_ni, state_d == FSM_SHIFT, cnt_d == cnt_q, "shift count")
  `MIDS_ASSERT_IMPL(a_pend_idle, clk_i, rst_ni, pend_q, !in_i.ready, "read pending while idle")

endmodule
